>>> sv/ecst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecst_pkg
// Shared operation codes, status codes and the row update result record.
// ----------------------------------------------------------------------------
package ecst_pkg;

	typedef enum logic [2:0] {
		FN_CREATE   = 3'd0,
		FN_LOOKUP   = 3'd1,
		FN_ADD      = 3'd2,
		FN_RETARGET = 3'd3,
		FN_UNLINK   = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_NOT_FOUND = 2'd1,
		STATUS_FULL      = 2'd2,
		STATUS_RANGE     = 2'd3
	} status_t;

	typedef struct packed {
		logic        wr_en;
		status_t     status;
		logic [31:0] found;
	} upd_t;

endpackage
`default_nettype wire

>>> sv/entity_component_slot_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// entity_component_slot_table
// Entity slot table holding a short list of (type, index) entries per slot,
// one memory row per slot, updated by read, modify and write back.
// ----------------------------------------------------------------------------
// The item's row is read and its fields are registered when it is accepted; in
// the execute state the result is registered at the output.
// Items do not overlap: a new item is accepted only in the idle state, after the
// write back of the last row, and only while the output register is free or read.
// Reset: after reset a clearing pass zeroes every slot count, one row a cycle,
// through all SLOT_TOTAL rows; no item is accepted during that pass.
module entity_component_slot_table #(
	parameter int SLOT_TOTAL = 512,
	parameter int MAX_COMPS  = 16,
	parameter int TYPE_BITS  = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// entity [8:0], comp_type [16:9], comp_index [48:17], zero [55:49]
	input  wire logic [55:0] s_tdata,
	// func [2:0]
	input  wire logic [2:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// status [1:0], new_entity [10:2], found_index [42:11], zero [47:43]
	output logic      [47:0] m_tdata
);
	import ecst_pkg::*;

	localparam int AW = (SLOT_TOTAL > 1) ? $clog2(SLOT_TOTAL) : 1;
	localparam int NW = $clog2(SLOT_TOTAL + 1);
	localparam int CW = $clog2(MAX_COMPS + 1);
	localparam int RW = CW + MAX_COMPS * (TYPE_BITS + 32);

	typedef enum logic [2:0] {
		S_CLEAR = 3'b001,
		S_IDLE  = 3'b010,
		S_EXEC  = 3'b100
	} state_t;

	state_t                state_q;
	logic   [AW-1:0]       clr_q;
	logic   [NW-1:0]       created_q;
	logic                  out_valid_q;
	logic   [42:0]         out_data_q;
	logic   [RW-1:0]       row_mem_q [SLOT_TOTAL];

	func_t                 func_s1;
	logic   [AW-1:0]       addr_s1;
	logic                  range_bad_s1;
	logic   [TYPE_BITS-1:0] typ_s1;
	logic   [31:0]         idx_s1;
	logic   [RW-1:0]       row_s1;

	logic                  accept;
	logic                  rd_en;
	logic   [AW-1:0]       rd_addr;
	logic                  wr_en;
	logic   [AW-1:0]       wr_addr;
	logic   [RW-1:0]       wr_data;
	logic   [RW-1:0]       row_new;
	upd_t                  upd;
	logic                  created_full;
	logic                  create_inc;
	status_t               res_status;
	logic   [8:0]          res_new;
	logic   [31:0]         res_found;

	assign s_tready = (state_q == S_IDLE) && (!out_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign rd_en    = accept;
	assign rd_addr  = AW'(s_tdata[8:0]);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_data_q};

	assign created_full = (created_q == NW'(SLOT_TOTAL));

	always_ff @(posedge clk) begin
		if (wr_en) row_mem_q[wr_addr] <= wr_data;
		if (rd_en) row_s1 <= row_mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1      <= func_t'(s_tuser);
			addr_s1      <= AW'(s_tdata[8:0]);
			range_bad_s1 <= (32'(s_tdata[8:0]) >= 32'(SLOT_TOTAL));
			typ_s1       <= TYPE_BITS'(s_tdata[16:9]);
			idx_s1       <= s_tdata[48:17];
		end
	end

	ecst_row_update #(
		.MAX_COMPS (MAX_COMPS),
		.TYPE_BITS (TYPE_BITS),
		.CW        (CW),
		.RW        (RW)
	) u_row_update (
		.row_in     (row_s1),
		.func       (func_s1),
		.comp_type  (typ_s1),
		.comp_index (idx_s1),
		.row_out    (row_new),
		.upd        (upd)
	);

	always_comb begin
		wr_en      = 1'b0;
		wr_addr    = addr_s1;
		wr_data    = row_new;
		create_inc = 1'b0;
		res_status = STATUS_OK;
		res_new    = 9'd0;
		res_found  = 32'd0;
		if (state_q == S_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else if (state_q == S_EXEC) begin
			unique case (func_s1)
				FN_CREATE: begin
					if (created_full) begin
						res_status = STATUS_FULL;
					end else begin
						wr_en      = 1'b1;
						wr_addr    = AW'(created_q);
						wr_data    = '0;
						res_new    = 9'(created_q);
						create_inc = 1'b1;
					end
				end
				FN_LOOKUP, FN_ADD, FN_RETARGET, FN_UNLINK: begin
					if (range_bad_s1) begin
						res_status = STATUS_RANGE;
					end else begin
						wr_en      = upd.wr_en;
						res_status = upd.status;
						res_found  = upd.found;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			created_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(SLOT_TOTAL - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
			if (create_inc) created_q <= created_q + NW'(1);
			if (state_q == S_EXEC) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EXEC) out_data_q <= {res_found, res_new, res_status};
	end

`ifndef SYNTH
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_EXEC))
		else $error("accepted item did not move to the execute cycle");
	a_exec_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |-> !out_valid_q)
		else $error("execute cycle found the output register occupied");
	a_exec_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |=> m_tvalid)
		else $error("execute cycle did not present a result");
	a_port_conflict: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("row memory read and write in the same cycle");
	a_created_bound: assert property (@(posedge clk) disable iff (!arst_n)
		created_q <= NW'(SLOT_TOTAL))
		else $error("created slot counter beyond the table size");
`endif

endmodule
`default_nettype wire

>>> sv/ecst_row_update.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecst_row_update
// Matches a type against every occupied entry of one entity row and builds
// the modified row for lookup, add, retarget and unlink.
// ----------------------------------------------------------------------------
module ecst_row_update #(
	parameter int MAX_COMPS = 16,
	parameter int TYPE_BITS = 8,
	parameter int CW        = $clog2(MAX_COMPS + 1),
	parameter int RW        = CW + MAX_COMPS * (TYPE_BITS + 32)
) (
	input  wire logic [RW-1:0]        row_in,
	input  wire ecst_pkg::func_t      func,
	input  wire logic [TYPE_BITS-1:0] comp_type,
	input  wire logic [31:0]          comp_index,
	output logic      [RW-1:0]        row_out,
	output ecst_pkg::upd_t            upd
);
	import ecst_pkg::*;

	localparam int EW = TYPE_BITS + 32;
	localparam int PW = (MAX_COMPS > 1) ? $clog2(MAX_COMPS) : 1;

	logic [CW-1:0]        count;
	logic [CW-1:0]        last;
	logic [CW-1:0]        ncount;
	logic [TYPE_BITS-1:0] etype [MAX_COMPS];
	logic [31:0]          eidx  [MAX_COMPS];
	logic [TYPE_BITS-1:0] ntype [MAX_COMPS];
	logic [31:0]          nidx  [MAX_COMPS];
	logic [MAX_COMPS-1:0] hit;
	logic [PW-1:0]        pos;
	logic                 any;

	assign count = row_in[CW-1:0];
	assign last  = count - CW'(1);

	for (genvar i = 0; i < MAX_COMPS; i++) begin : g_entry
		assign etype[i] = row_in[CW + i*EW +: TYPE_BITS];
		assign eidx[i]  = row_in[CW + i*EW + TYPE_BITS +: 32];
		assign hit[i]   = (CW'(i) < count) && (etype[i] == comp_type);
		assign row_out[CW + i*EW +: EW] = {nidx[i], ntype[i]};
	end
	assign row_out[CW-1:0] = ncount;

	always_comb begin
		pos = '0;
		any = 1'b0;
		for (int i = MAX_COMPS - 1; i >= 0; i--) begin
			if (hit[i]) begin
				pos = PW'(i);
				any = 1'b1;
			end
		end
	end

	always_comb begin
		ntype  = etype;
		nidx   = eidx;
		ncount = count;
		upd    = '{wr_en: 1'b0, status: STATUS_OK, found: 32'd0};
		unique case (func)
			FN_LOOKUP: begin
				if (any) upd.found = eidx[pos];
				else upd.status = STATUS_NOT_FOUND;
			end
			FN_ADD: begin
				if (count >= CW'(MAX_COMPS)) begin
					upd.status = STATUS_FULL;
				end else begin
					ntype[count[PW-1:0]] = comp_type;
					nidx[count[PW-1:0]]  = comp_index;
					ncount               = count + CW'(1);
					upd.wr_en            = 1'b1;
				end
			end
			FN_RETARGET: begin
				if (any) begin
					nidx[pos] = comp_index;
					upd.wr_en = 1'b1;
				end else begin
					upd.status = STATUS_NOT_FOUND;
				end
			end
			FN_UNLINK: begin
				if (any) begin
					ntype[pos] = etype[last[PW-1:0]];
					nidx[pos]  = eidx[last[PW-1:0]];
					ncount     = last;
					upd.wr_en  = 1'b1;
				end else begin
					upd.status = STATUS_NOT_FOUND;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire
